// ===== sv/okvt_pkg.sv =====
package okvt_pkg;

    localparam int DEPTH = 16;
    localparam int KEY_W = 16;
    localparam int VAL_W = 32;
    localparam int POS_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMD_W = 3;
    localparam int STS_W = 2;

    localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READPOS = 3'd4;

    localparam logic [STS_W-1:0] STS_OK   = 2'd0;
    localparam logic [STS_W-1:0] STS_NEW  = 2'd1;
    localparam logic [STS_W-1:0] STS_MISS = 2'd2;
    localparam logic [STS_W-1:0] STS_FULL = 2'd3;

    typedef struct packed {
        logic used;
        logic load;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic             hit;
        logic [STS_W-1:0] status;
        logic [VAL_W-1:0] read_value;
        logic [KEY_W-1:0] read_key;
        logic [POS_W-1:0] entry_position;
        logic [CNT_W-1:0] entry_count;
    } result_t;

endpackage

// ===== sv/okvt_req_if.sv =====
interface okvt_req_if;
    logic                         valid;
    logic                         ready;
    logic [okvt_pkg::CMD_W-1:0]   command;
    logic [okvt_pkg::KEY_W-1:0]   key;
    logic [okvt_pkg::VAL_W-1:0]   write_value;
    logic [okvt_pkg::POS_W-1:0]   position;

    modport source (output valid, command, key, write_value, position, input ready);
    modport sink (input valid, command, key, write_value, position, output ready);
endinterface

// ===== sv/okvt_rsp_if.sv =====
interface okvt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic [okvt_pkg::STS_W-1:0]   status;
    logic [okvt_pkg::VAL_W-1:0]   read_value;
    logic [okvt_pkg::KEY_W-1:0]   read_key;
    logic [okvt_pkg::POS_W-1:0]   entry_position;
    logic [okvt_pkg::CNT_W-1:0]   entry_count;

    modport source (output valid, hit, status, read_value, read_key, entry_position,
                    entry_count, input ready);
    modport sink (input valid, hit, status, read_value, read_key, entry_position,
                  entry_count, output ready);
endinterface

// ===== sv/okvt_cell.sv =====
module okvt_cell (
    input  logic                       clk,
    input  okvt_pkg::cell_ctrl_t       ctrl,
    input  logic [okvt_pkg::KEY_W-1:0] new_key,
    input  logic [okvt_pkg::VAL_W-1:0] new_value,
    input  logic [okvt_pkg::KEY_W-1:0] next_key,
    input  logic [okvt_pkg::VAL_W-1:0] next_value,
    output logic [okvt_pkg::KEY_W-1:0] key,
    output logic [okvt_pkg::VAL_W-1:0] value,
    output logic                       match
);

    logic [okvt_pkg::KEY_W-1:0] key_reg;
    logic [okvt_pkg::VAL_W-1:0] value_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            key_reg   <= new_key;
            value_reg <= new_value;
        end
        else if (ctrl.shift)
        begin
            // close the gap left by a delete
            key_reg   <= next_key;
            value_reg <= next_value;
        end
    end

    assign key   = key_reg;
    assign value = value_reg;
    assign match = ctrl.used && (key_reg == new_key);

endmodule

// ===== sv/ordered_key_value_table.sv =====
// an accepted word waits in the command registers; in EXEC, once the output register is free or
// being taken, the compare-and-update pass over the cell row runs and the result is registered;
// new words enter only in idle; the output register lets one in while a result waits to be taken
// reset clears the entry count and handshake state; cell contents stay unknown until written
module ordered_key_value_table (
    input  logic       clk,
    input  logic       rst_n,
    okvt_req_if.sink   req,
    okvt_rsp_if.source rsp
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic [okvt_pkg::CNT_W-1:0] count_reg, count_next;
    logic out_valid_reg, out_valid_next;
    okvt_pkg::result_t result_reg, result_next;

    logic [okvt_pkg::CMD_W-1:0] cmd_reg;
    logic [okvt_pkg::KEY_W-1:0] key_reg;
    logic [okvt_pkg::VAL_W-1:0] wval_reg;
    logic [okvt_pkg::POS_W-1:0] pos_reg;

    okvt_pkg::cell_ctrl_t       ctrl [okvt_pkg::DEPTH];
    logic [okvt_pkg::KEY_W-1:0] cell_key [okvt_pkg::DEPTH];
    logic [okvt_pkg::VAL_W-1:0] cell_value [okvt_pkg::DEPTH];
    logic [okvt_pkg::DEPTH-1:0] match;

    logic                       accept;
    logic                       exec_go;
    logic                       any_hit;
    logic                       full;
    logic                       pos_ok;
    logic [okvt_pkg::POS_W-1:0] at_pos;
    logic [okvt_pkg::VAL_W-1:0] hit_value;

    assign accept  = req.valid && req.ready;
    assign exec_go = (state_reg == ST_EXEC) && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= req.command;
            key_reg  <= req.key;
            wval_reg <= req.write_value;
            pos_reg  <= req.position;
        end
    end

    genvar g;
    generate
        for (g = 0; g < okvt_pkg::DEPTH; g++)
        begin : g_cell
            logic [okvt_pkg::KEY_W-1:0] nk;
            logic [okvt_pkg::VAL_W-1:0] nv;
            if (g + 1 < okvt_pkg::DEPTH)
            begin : g_mid
                assign nk = cell_key[g+1];
                assign nv = cell_value[g+1];
            end
            else
            begin : g_last
                assign nk = cell_key[g];
                assign nv = cell_value[g];
            end
            okvt_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl[g]),
                .new_key    (key_reg),
                .new_value  (wval_reg),
                .next_key   (nk),
                .next_value (nv),
                .key        (cell_key[g]),
                .value      (cell_value[g]),
                .match      (match[g])
            );
        end
    endgenerate

    // keys are unique, so at most one cell matches
    always_comb
    begin
        at_pos    = '0;
        hit_value = '0;
        for (int i = 0; i < okvt_pkg::DEPTH; i++)
        begin
            if (match[i])
            begin
                at_pos    = at_pos | okvt_pkg::POS_W'(i);
                hit_value = hit_value | cell_value[i];
            end
        end
    end

    assign any_hit = |match;
    assign full    = (count_reg == okvt_pkg::CNT_W'(okvt_pkg::DEPTH));
    assign pos_ok  = (okvt_pkg::CNT_W'(pos_reg) < count_reg);

    always_comb
    begin
        for (int i = 0; i < okvt_pkg::DEPTH; i++)
        begin
            ctrl[i].used  = okvt_pkg::CNT_W'(i) < count_reg;
            ctrl[i].load  = 1'b0;
            ctrl[i].shift = 1'b0;
            if (exec_go && cmd_reg == okvt_pkg::CMD_WRITE)
            begin
                if (any_hit)
                    ctrl[i].load = match[i];
                else
                    ctrl[i].load = !full && (okvt_pkg::CNT_W'(i) == count_reg);
            end
            if (exec_go && cmd_reg == okvt_pkg::CMD_DELETE && any_hit)
                ctrl[i].shift = okvt_pkg::POS_W'(i) >= at_pos;
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        result_next = '0;
        case (cmd_reg)
            okvt_pkg::CMD_WRITE:
            begin
                if (any_hit)
                begin
                    result_next.hit            = 1'b1;
                    result_next.status         = okvt_pkg::STS_OK;
                    result_next.read_value     = wval_reg;
                    result_next.read_key       = key_reg;
                    result_next.entry_position = at_pos;
                end
                else if (!full)
                begin
                    result_next.status         = okvt_pkg::STS_NEW;
                    result_next.read_value     = wval_reg;
                    result_next.read_key       = key_reg;
                    result_next.entry_position = count_reg[okvt_pkg::POS_W-1:0];
                    count_next                 = count_reg + 1'b1;
                end
                else
                    result_next.status = okvt_pkg::STS_FULL;
            end
            okvt_pkg::CMD_LOOKUP, okvt_pkg::CMD_DELETE:
            begin
                if (any_hit)
                begin
                    result_next.hit            = 1'b1;
                    result_next.read_value     = hit_value;
                    result_next.read_key       = key_reg;
                    result_next.entry_position = at_pos;
                    if (cmd_reg == okvt_pkg::CMD_DELETE)
                        count_next = count_reg - 1'b1;
                end
                else
                    result_next.status = okvt_pkg::STS_MISS;
            end
            okvt_pkg::CMD_CLEAR:
            begin
                count_next = '0;
            end
            okvt_pkg::CMD_READPOS:
            begin
                result_next.entry_position = pos_reg;
                if (pos_ok)
                begin
                    result_next.hit        = 1'b1;
                    result_next.read_value = cell_value[pos_reg];
                    result_next.read_key   = cell_key[pos_reg];
                end
                else
                    result_next.status = okvt_pkg::STS_MISS;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        result_next.entry_count = count_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (rsp.ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (exec_go)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
            result_reg <= result_next;
    end

    assign req.ready          = (state_reg == ST_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.hit            = result_reg.hit;
    assign rsp.status         = result_reg.status;
    assign rsp.read_value     = result_reg.read_value;
    assign rsp.read_key       = result_reg.read_key;
    assign rsp.entry_position = result_reg.entry_position;
    assign rsp.entry_count    = result_reg.entry_count;

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIMEOUT_CYCLES = 200000;
    localparam int HOLD_CYCLES    = 80;
    localparam int POOL_SIZE      = 24;

    // command codes the block leaves unused
    localparam logic [okvt_pkg::CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [okvt_pkg::CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    okvt_req_if req_if();
    okvt_rsp_if rsp_if();

    ordered_key_value_table u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // shadow copy of the table
    logic [okvt_pkg::KEY_W-1:0] shadow_key [okvt_pkg::DEPTH];
    logic [okvt_pkg::VAL_W-1:0] shadow_val [okvt_pkg::DEPTH];
    int                         shadow_count = 0;

    logic [okvt_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
    okvt_pkg::result_t          pending_results [$];
    okvt_pkg::result_t          oldest_result;

    int error_count = 0;
    int cycle_count = 0;
    bit idle_on     = 1'b1;
    bit traffic_on  = 1'b0;
    bit hold_request = 1'b0;
    int hold_left   = 0;
    int stall_left  = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int find_shadow_key(input logic [okvt_pkg::KEY_W-1:0] k);
        for (int i = 0; i < shadow_count; i++)
        begin
            if (shadow_key[i] == k)
                return i;
        end
        return -1;
    endfunction

    function automatic okvt_pkg::result_t apply_table_command(
        input logic [okvt_pkg::CMD_W-1:0] cmd,
        input logic [okvt_pkg::KEY_W-1:0] k,
        input logic [okvt_pkg::VAL_W-1:0] v,
        input logic [okvt_pkg::POS_W-1:0] pos
    );
        okvt_pkg::result_t r;
        int                at;
        r  = '0;
        at = find_shadow_key(k);
        case (cmd)
            okvt_pkg::CMD_WRITE:
            begin
                if (at >= 0)
                begin
                    shadow_val[at]   = v;
                    r.hit            = 1'b1;
                    r.status         = okvt_pkg::STS_OK;
                    r.read_value     = v;
                    r.read_key       = k;
                    r.entry_position = okvt_pkg::POS_W'(at);
                end
                else if (shadow_count < okvt_pkg::DEPTH)
                begin
                    shadow_key[shadow_count] = k;
                    shadow_val[shadow_count] = v;
                    r.status         = okvt_pkg::STS_NEW;
                    r.read_value     = v;
                    r.read_key       = k;
                    r.entry_position = okvt_pkg::POS_W'(shadow_count);
                    shadow_count++;
                end
                else
                    r.status = okvt_pkg::STS_FULL;
            end
            okvt_pkg::CMD_LOOKUP:
            begin
                if (at >= 0)
                begin
                    r.hit            = 1'b1;
                    r.read_value     = shadow_val[at];
                    r.read_key       = k;
                    r.entry_position = okvt_pkg::POS_W'(at);
                end
                else
                    r.status = okvt_pkg::STS_MISS;
            end
            okvt_pkg::CMD_DELETE:
            begin
                if (at >= 0)
                begin
                    r.hit            = 1'b1;
                    r.read_value     = shadow_val[at];
                    r.read_key       = k;
                    r.entry_position = okvt_pkg::POS_W'(at);
                    // close the gap left by the removed entry
                    for (int j = at; j + 1 < shadow_count; j++)
                    begin
                        shadow_key[j] = shadow_key[j + 1];
                        shadow_val[j] = shadow_val[j + 1];
                    end
                    shadow_count--;
                end
                else
                    r.status = okvt_pkg::STS_MISS;
            end
            okvt_pkg::CMD_CLEAR:
                shadow_count = 0;
            okvt_pkg::CMD_READPOS:
            begin
                r.entry_position = pos;
                if (int'(pos) < shadow_count)
                begin
                    r.hit        = 1'b1;
                    r.read_value = shadow_val[pos];
                    r.read_key   = shadow_key[pos];
                end
                else
                    r.status = okvt_pkg::STS_MISS;
            end
            default:
                ;
        endcase
        r.entry_count = okvt_pkg::CNT_W'(shadow_count);
        return r;
    endfunction

    function automatic void compare_field(
        input string       name,
        input logic [31:0] want,
        input logic [31:0] got
    );
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // drives one word from the falling edge and waits for it to be taken
    task automatic send_word(
        input logic [okvt_pkg::CMD_W-1:0] cmd,
        input logic [okvt_pkg::KEY_W-1:0] k,
        input logic [okvt_pkg::VAL_W-1:0] v,
        input logic [okvt_pkg::POS_W-1:0] pos
    );
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid       = 1'b1;
        req_if.command     = cmd;
        req_if.key         = k;
        req_if.write_value = v;
        req_if.position    = pos;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        pending_results.push_back(apply_table_command(cmd, k, v, pos));
    endtask

    function automatic logic [okvt_pkg::KEY_W-1:0] choose_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && shadow_count > 0)
            return shadow_key[$urandom_range(0, shadow_count - 1)];
        else if (sel < 9)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            return okvt_pkg::KEY_W'($urandom);
    endfunction

    task automatic test_directed();
        logic [okvt_pkg::CMD_W-1:0] cmd;
        send_word(okvt_pkg::CMD_LOOKUP, 16'h1234, 32'h0, 4'd0);
        send_word(okvt_pkg::CMD_DELETE, 16'h1234, 32'h0, 4'd0);
        send_word(okvt_pkg::CMD_READPOS, 16'h0, 32'h0, 4'd15);
        send_word(okvt_pkg::CMD_WRITE, 16'h0000, 32'h0000_0000, 4'd0);
        send_word(okvt_pkg::CMD_WRITE, 16'hFFFF, 32'hFFFF_FFFF, 4'd15);
        send_word(okvt_pkg::CMD_WRITE, 16'h0000, 32'hFFFF_FFFF, 4'd0);
        send_word(okvt_pkg::CMD_LOOKUP, 16'hFFFF, 32'h0, 4'd0);
        send_word(okvt_pkg::CMD_READPOS, 16'h0, 32'h0, 4'd0);
        for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
        begin
            cmd = okvt_pkg::CMD_W'(c);
            send_word(cmd, 16'hFFFF, 32'hFFFF_FFFF, 4'd15);
        end
        // fill the table to its depth
        for (int i = 0; i < okvt_pkg::DEPTH - 2; i++)
            send_word(okvt_pkg::CMD_WRITE, okvt_pkg::KEY_W'(16'h1000 + i), $urandom, 4'd0);
        send_word(okvt_pkg::CMD_WRITE, 16'hBEEF, 32'hDEAD_0001, 4'd0);
        send_word(okvt_pkg::CMD_WRITE, 16'hFFFF, 32'h5A5A_5A5A, 4'd0);
        send_word(okvt_pkg::CMD_READPOS, 16'h0, 32'h0, 4'd15);
        send_word(okvt_pkg::CMD_DELETE, 16'h0000, 32'h0, 4'd0);
        send_word(okvt_pkg::CMD_DELETE, 16'h1006, 32'h0, 4'd0);
        send_word(okvt_pkg::CMD_DELETE, 16'h100D, 32'h0, 4'd0);
        send_word(okvt_pkg::CMD_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 4'd15);
        send_word(okvt_pkg::CMD_READPOS, 16'h0, 32'h0, 4'd0);
    endtask

    task automatic test_random_mix(input int n_words);
        logic [okvt_pkg::CMD_W-1:0] cmd;
        logic [okvt_pkg::KEY_W-1:0] k;
        logic [okvt_pkg::POS_W-1:0] pos;
        int                         pick;
        repeat (n_words)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                cmd = okvt_pkg::CMD_WRITE;
            else if (pick < 60)
                cmd = okvt_pkg::CMD_LOOKUP;
            else if (pick < 75)
                cmd = okvt_pkg::CMD_DELETE;
            else if (pick < 91)
                cmd = okvt_pkg::CMD_READPOS;
            else if (pick < 94)
                cmd = okvt_pkg::CMD_CLEAR;
            else
                cmd = okvt_pkg::CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
            k = choose_key();
            if (shadow_count > 0 && $urandom_range(0, 3) != 0)
                pos = okvt_pkg::POS_W'($urandom_range(0, shadow_count - 1));
            else
                pos = okvt_pkg::POS_W'($urandom_range(0, 15));
            send_word(cmd, k, $urandom, pos);
        end
    endtask

    // the sink holds off while words keep coming, so the block fills and stalls
    task automatic test_backpressure(input int n_words);
        @(posedge clk);
        hold_request = 1'b1;
        test_random_mix(n_words);
    endtask

    task automatic test_no_idle(input int n_words);
        idle_on = 1'b0;
        test_random_mix(n_words);
    endtask

    always @(negedge clk)
    begin
        if (!traffic_on)
            rsp_if.ready = 1'b0;
        else if (hold_request)
        begin
            hold_request  = 1'b0;
            hold_left     = HOLD_CYCLES - 1;
            rsp_if.ready  = 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp_if.ready = 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_if.ready = 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left   = $urandom_range(1, 9) - 1;
            rsp_if.ready = 1'b0;
        end
        else
            rsp_if.ready = 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: result word with no command pending", $time);
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                compare_field("hit", 32'(oldest_result.hit), 32'(rsp_if.hit));
                compare_field("status", 32'(oldest_result.status), 32'(rsp_if.status));
                compare_field("read_value", oldest_result.read_value, rsp_if.read_value);
                compare_field("read_key", 32'(oldest_result.read_key), 32'(rsp_if.read_key));
                compare_field("entry_position", 32'(oldest_result.entry_position),
                              32'(rsp_if.entry_position));
                compare_field("entry_count", 32'(oldest_result.entry_count),
                              32'(rsp_if.entry_count));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        req_if.valid       = 1'b0;
        req_if.command     = okvt_pkg::CMD_WRITE;
        req_if.key         = '0;
        req_if.write_value = '0;
        req_if.position    = '0;
        rsp_if.ready       = 1'b0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = okvt_pkg::KEY_W'($urandom);

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);
        traffic_on = 1'b1;

        test_directed();
        test_random_mix(380);
        test_backpressure(40);
        test_no_idle(130);

        @(negedge clk);
        req_if.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
